// File: rtl/imoa_pkg.sv
package imoa_pkg;

    // operation codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MOD  = 4'd4;
    localparam logic [3:0] OP_POW  = 4'd5;
    localparam logic [3:0] OP_FACT = 4'd6;
    localparam logic [3:0] OP_SQR  = 4'd7;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // datapath step selects
    localparam logic [2:0] DP_LOAD   = 3'd0;
    localparam logic [2:0] DP_MUL_AB = 3'd1;
    localparam logic [2:0] DP_DIV    = 3'd2;
    localparam logic [2:0] DP_POW    = 3'd3;
    localparam logic [2:0] DP_FACT_A = 3'd4;
    localparam logic [2:0] DP_FACT_B = 3'd5;
    localparam logic [2:0] DP_SQR    = 3'd6;
    localparam logic [2:0] DP_IDLE   = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic [2:0] op;
        logic       step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_zero;
    } t_dp_stat;

endpackage

// File: rtl/imoa_datapath.sv
module imoa_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  imoa_pkg::t_dp_cmd     i_cmd,
    input  logic [3:0]            i_mode,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    input  logic [7:0]            i_cnt,
    output imoa_pkg::t_dp_stat    o_stat,
    output logic [31:0]           o_value,
    output logic [31:0]           o_second
);
    localparam int W = DATA_WIDTH;
    localparam int CW = 8;
    localparam logic [CW-1:0] FACT_CAP = CW'(2 * W + 2);

    logic [W-1:0] r_a, r_b, r_acc, r_sq, r_acc2, r_rem;
    logic         r_sa, r_sb, r_bpos, r_apos;
    logic [W-1:0] n_a, n_b, n_acc, n_sq, n_acc2, n_rem;
    logic [W-1:0] a_w, b_w, mag_a, mag_b, sub_r, mul_x, mul_y, mul_p, mul_q, mul_r;
    logic [W:0]   trial;
    logic [W-1:0] k_w;
    logic [W-1:0] quo, rem;

    assign a_w   = W'(i_a);
    assign b_w   = W'(i_b);
    assign mag_a = a_w[W-1] ? (~a_w + W'(1)) : a_w;
    assign mag_b = b_w[W-1] ? (~b_w + W'(1)) : b_w;
    assign k_w   = W'(i_cnt);

    // shared multipliers, one product per cycle each
    always_comb begin
        mul_x = r_acc;
        mul_y = r_sq;
        mul_q = r_sq;
        unique case (i_cmd.op)
            imoa_pkg::DP_MUL_AB: begin mul_x = r_a;   mul_y = r_b;  mul_q = r_b;  end
            imoa_pkg::DP_FACT_A: begin mul_x = r_acc; mul_y = k_w;  mul_q = r_b;  end
            imoa_pkg::DP_FACT_B: begin mul_x = r_acc2; mul_y = k_w; mul_q = r_b;  end
            imoa_pkg::DP_SQR:    begin mul_x = r_a;   mul_y = r_a;  mul_q = r_b;  end
            default:             begin mul_x = r_acc; mul_y = r_sq; mul_q = r_sq; end
        endcase
    end
    assign mul_p = mul_x * mul_y;
    assign mul_r = mul_q * mul_q;

    // restoring divide step on magnitudes held in r_a, divisor in r_b
    assign trial = {r_rem, r_a[W-1]} - {1'b0, r_b};
    assign sub_r = trial[W-1:0];

    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_sq = r_sq; n_acc2 = r_acc2; n_rem = r_rem;
        if (i_cmd.step) begin
            unique case (i_cmd.op)
                imoa_pkg::DP_LOAD: begin
                    n_rem = '0;
                    n_acc = W'(1);
                    n_acc2 = W'(1);
                    if (i_mode == imoa_pkg::OP_DIV || i_mode == imoa_pkg::OP_MOD) begin
                        n_a = mag_a;
                        n_b = mag_b;
                    end else begin
                        n_a = a_w;
                        n_b = b_w;
                    end
                    n_sq = a_w;
                end
                imoa_pkg::DP_MUL_AB: n_acc = mul_p;
                imoa_pkg::DP_DIV: begin
                    n_a = {r_a[W-2:0], ~trial[W]};
                    n_rem = trial[W] ? {r_rem[W-2:0], r_a[W-1]} : sub_r;
                end
                imoa_pkg::DP_POW: begin
                    if (r_b[i_cnt[$clog2(W)-1:0]]) n_acc = mul_p;
                    n_sq = mul_r;
                end
                imoa_pkg::DP_FACT_A: if (r_apos && k_w <= r_a && i_cnt <= FACT_CAP) n_acc = mul_p;
                imoa_pkg::DP_FACT_B: if (r_bpos && k_w <= r_b && i_cnt <= FACT_CAP) n_acc2 = mul_p;
                imoa_pkg::DP_SQR: begin n_acc = mul_p; n_acc2 = mul_r; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_sq <= n_sq; r_acc2 <= n_acc2; r_rem <= n_rem;
        if (i_cmd.step && i_cmd.op == imoa_pkg::DP_LOAD) begin
            r_sa   <= a_w[W-1];
            r_sb   <= b_w[W-1];
            r_apos <= !a_w[W-1] && a_w != '0;
            r_bpos <= !b_w[W-1] && b_w != '0;
        end
    end

    // sign fixup for quotient and remainder
    assign quo = (r_sa ^ r_sb) ? (~r_a + W'(1)) : r_a;
    assign rem = r_sa ? (~r_rem + W'(1)) : r_rem;

    assign o_stat.div_zero  = (b_w == '0);

    always_comb begin
        o_value  = 32'(r_acc);
        o_second = 32'(r_acc2);
        if (i_cmd.op == imoa_pkg::DP_DIV)
            o_value = (i_mode == imoa_pkg::OP_DIV) ? 32'(quo) : 32'(rem);
        else if (i_cmd.op == imoa_pkg::DP_POW)
            o_value = (r_bpos) ? 32'(r_acc) : 32'd1;
    end
endmodule

// File: rtl/imoa_ctrl.sv
module imoa_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_mode,
    input  imoa_pkg::t_dp_stat i_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_capture,
    output logic [1:0]         o_status,
    output logic               o_has_second,
    output logic               o_zero_value,
    output imoa_pkg::t_dp_cmd  o_cmd,
    output logic [7:0]         o_cnt
);
    localparam int W = DATA_WIDTH;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_FB   = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [7:0] LAST_BIT = 8'(W - 1);
    localparam logic [7:0] FACT_END = 8'(2 * W + 2);

    logic [2:0] r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic [3:0] r_mode;
    logic [1:0] r_st;
    logic       r_dz;
    logic [2:0] run_op;

    always_comb begin
        unique case (r_mode) inside
            imoa_pkg::OP_ADD, imoa_pkg::OP_SUB: run_op = imoa_pkg::DP_IDLE;
            imoa_pkg::OP_MUL:                   run_op = imoa_pkg::DP_MUL_AB;
            imoa_pkg::OP_DIV, imoa_pkg::OP_MOD: run_op = imoa_pkg::DP_DIV;
            imoa_pkg::OP_POW:                   run_op = imoa_pkg::DP_POW;
            imoa_pkg::OP_FACT:                  run_op = imoa_pkg::DP_FACT_A;
            imoa_pkg::OP_SQR:                   run_op = imoa_pkg::DP_SQR;
            default:                            run_op = imoa_pkg::DP_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cnt   = r_cnt;

    // controller sequencing
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd.op = run_op;
        o_cmd.step = 1'b0;
        o_capture = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op = imoa_pkg::DP_LOAD;
                if (i_valid) begin
                    o_cmd.step = 1'b1;
                    n_state = S_RUN;
                    n_cnt = (i_mode == imoa_pkg::OP_FACT) ? 8'd2 : 8'd0;
                end
            end
            S_RUN: begin
                o_cmd.step = !r_dz;
                n_cnt = r_cnt + 8'd1;
                unique case (run_op) inside
                    imoa_pkg::DP_DIV, imoa_pkg::DP_POW: begin
                        if (r_cnt == LAST_BIT || r_dz) n_state = S_DONE;
                    end
                    imoa_pkg::DP_FACT_A: begin
                        if (r_cnt == FACT_END) begin n_state = S_FB; n_cnt = 8'd2; end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FB: begin
                o_cmd.op = imoa_pkg::DP_FACT_B;
                o_cmd.step = 1'b1;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == FACT_END) n_state = S_DONE;
            end
            S_DONE: begin
                o_capture = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = imoa_pkg::DP_IDLE;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_has_second = (r_mode == imoa_pkg::OP_FACT || r_mode == imoa_pkg::OP_SQR);
    assign o_zero_value = (r_st != imoa_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= i_mode;
            r_dz <= (i_mode == imoa_pkg::OP_DIV || i_mode == imoa_pkg::OP_MOD) && i_stat.div_zero;
            if (i_mode[3])
                r_st <= imoa_pkg::ST_INVALID;
            else if ((i_mode == imoa_pkg::OP_DIV || i_mode == imoa_pkg::OP_MOD)
                     && i_stat.div_zero)
                r_st <= imoa_pkg::ST_DIVZERO;
            else
                r_st <= imoa_pkg::ST_OK;
        end
    end
endmodule

// File: rtl/integer_multi_op_alu_core.sv
// sequence, input item to result valid: load in idle, then the run state, then done
// (capture) and out; div/mod/power loop in the run state over the operand bits, and
// factorial runs one loop per operand (run, then S_FB; counter 2..66 per operand); add,
// sub, mul, square, invalid mode and divide by zero leave the run state at once
// throughput: one item at a time, the next is taken in the cycle after the result leaves
// reset: synchronous active-low i_rst_n returns the controller to idle
module integer_multi_op_alu_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_axis_tuser,  // mode[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // value[31:0], second_value[63:32], has_second[64], pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    imoa_pkg::t_dp_cmd  cmd;
    imoa_pkg::t_dp_stat stat;
    logic [7:0]  cnt;
    logic [31:0] dp_value, dp_second;
    logic [31:0] r_value, r_second;
    logic        capture, has_second, zero_value;
    logic [1:0]  status;
    logic [3:0]  r_mode_hold;
    logic [3:0]  mode_in;

    assign mode_in = s_axis_tready ? s_axis_tuser : r_mode_hold;
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_mode_hold <= s_axis_tuser;
    end

    imoa_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tuser), .i_stat(stat),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_capture(capture), .o_status(status), .o_has_second(has_second),
        .o_zero_value(zero_value), .o_cmd(cmd), .o_cnt(cnt)
    );

    imoa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_mode(mode_in),
        .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]), .i_cnt(cnt),
        .o_stat(stat), .o_value(dp_value), .o_second(dp_second)
    );

    // result register, add and sub formed here from the held operands
    logic [31:0] r_a, r_b;
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_a <= s_axis_tdata[31:0];
            r_b <= s_axis_tdata[63:32];
        end
        if (capture) begin
            if (zero_value) r_value <= '0;
            else if (r_mode_hold == imoa_pkg::OP_ADD) r_value <= 32'(DATA_WIDTH'(r_a + r_b));
            else if (r_mode_hold == imoa_pkg::OP_SUB) r_value <= 32'(DATA_WIDTH'(r_a - r_b));
            else r_value <= dp_value;
            r_second <= has_second ? dp_second : '0;
        end
    end

    assign m_axis_tdata = {7'd0, has_second, r_second, r_value};
    assign m_axis_tuser = status;
endmodule

// File: tb/integer_multi_op_alu_core_tb.sv
module integer_multi_op_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] second_value;
        logic        has_second;
        logic [1:0]  status;
    } t_alu_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // operand_a[31:0], operand_b[63:32]
    logic [3:0]  s_axis_tuser = '0;   // mode[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // value[31:0], second_value[63:32], has_second[64], pad
    logic [1:0]  m_axis_tuser;        // status[1:0]

    t_alu_result expected_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;
    bit          hold_off = 1'b0;

    integer_multi_op_alu_core #(.DATA_WIDTH(32)) dut (.*);

    always #5 i_clk = ~i_clk;

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("integer_multi_op_alu_core_tb NOT OK");
            $finish;
        end
    end

    // wrapped arithmetic helpers
    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] e);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 32'd1;
        sq = base;
        if (e[31] || e == 0) return 32'd1;
        for (int k = 0; k < 32; k++) begin
            if (e[k]) acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic logic [31:0] wrap_factorial(logic [31:0] n);
        logic [31:0] acc;
        int lim;
        acc = 32'd1;
        if (n[31] || n == 0) return 32'd1;
        lim = (n > 66) ? 66 : int'(n);
        for (int k = 2; k <= lim; k++) acc = acc * k;
        return acc;
    endfunction

    function automatic t_alu_result compute_alu(logic [3:0] mode, logic [31:0] a,
                                                logic [31:0] b);
        t_alu_result r;
        logic [31:0] ma;
        logic [31:0] mb;
        r = '0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (mode)
            imoa_pkg::OP_ADD: r.value = a + b;
            imoa_pkg::OP_SUB: r.value = a - b;
            imoa_pkg::OP_MUL: r.value = a * b;
            imoa_pkg::OP_DIV, imoa_pkg::OP_MOD: begin
                if (b == 0) begin
                    r.status = imoa_pkg::ST_DIVZERO;
                end else if (mode == imoa_pkg::OP_DIV) begin
                    r.value = ma / mb;
                    if (a[31] != b[31]) r.value = -r.value;
                end else begin
                    r.value = ma % mb;
                    if (a[31]) r.value = -r.value;
                end
            end
            imoa_pkg::OP_POW: r.value = wrap_power(a, b);
            imoa_pkg::OP_FACT: begin
                r.value = wrap_factorial(a);
                r.second_value = wrap_factorial(b);
                r.has_second = 1'b1;
            end
            imoa_pkg::OP_SQR: begin
                r.value = a * a;
                r.second_value = b * b;
                r.has_second = 1'b1;
            end
            default: r.status = imoa_pkg::ST_INVALID;
        endcase
        return r;
    endfunction

    // send one item and queue its prediction
    task automatic send_item(logic [3:0] mode, logic [31:0] a, logic [31:0] b);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(compute_alu(mode, a, b));
        @(negedge i_clk);
    endtask

    // receiver ready with random bursts of stall
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_alu_result got;
        t_alu_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[64], m_axis_tuser};
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t value exp %h got %h", $time, want.value, got.value);
                    error_count++;
                end
                if (got.second_value !== want.second_value) begin
                    $display("%0t second_value exp %h got %h", $time,
                             want.second_value, got.second_value);
                    error_count++;
                end
                if (got.has_second !== want.has_second) begin
                    $display("%0t has_second exp %b got %b", $time,
                             want.has_second, got.has_second);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return -$urandom_range(0, 40);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // extremes and special cases
    task automatic test_directed();
        for (int m = 0; m < 16; m++) send_item(4'(m), 32'h7fff_ffff, 32'h8000_0000);
        send_item(imoa_pkg::OP_DIV, 32'd7, 32'd0);
        send_item(imoa_pkg::OP_MOD, 32'hffff_fff9, 32'd0);
        send_item(imoa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(imoa_pkg::OP_MOD, 32'h8000_0000, 32'hffff_ffff);
        send_item(imoa_pkg::OP_MOD, 32'hffff_fff9, 32'd2);
        send_item(imoa_pkg::OP_POW, 32'd3, 32'd0);
        send_item(imoa_pkg::OP_POW, 32'hffff_fffe, 32'd5);
        send_item(imoa_pkg::OP_FACT, 32'd33, 32'd34);
        send_item(imoa_pkg::OP_FACT, 32'd0, 32'hffff_fffb);
        send_item(imoa_pkg::OP_SQR, 32'h8000_0000, 32'hffff_ffff);
    endtask

    // random operations and operands
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_item($urandom_range(0, 9) == 0 ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(0, 7)),
                      pick_operand(), pick_operand());
    endtask

    // receiver stalls long so the block backs up
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(4);
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(250);
        test_backpressure();
        test_random(200);
        idle_enable = 1'b0;
        test_random(70);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("integer_multi_op_alu_core_tb OK");
        else
            $display("integer_multi_op_alu_core_tb NOT OK");
        $finish;
    end
endmodule
